// ----- rtl/core/gdsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdsp_pkg
// Shared types and codes for the GDSII record stream parser: record types,
// nesting flag positions, event, kind and error codes, transaction structs.
// ----------------------------------------------------------------------------
package gdsp_pkg;

  // Record types that the parser acts on
  localparam logic [15:0] RT_BGNLIB   = 16'h0102;
  localparam logic [15:0] RT_ENDLIB   = 16'h0400;
  localparam logic [15:0] RT_BGNSTR   = 16'h0502;
  localparam logic [15:0] RT_ENDSTR   = 16'h0700;
  localparam logic [15:0] RT_BOUNDARY = 16'h0800;
  localparam logic [15:0] RT_PATH     = 16'h0900;
  localparam logic [15:0] RT_SREF     = 16'h0A00;
  localparam logic [15:0] RT_ENDEL    = 16'h1100;
  localparam logic [15:0] RT_XY       = 16'h1003;
  localparam logic [15:0] RT_MAG      = 16'h1B05;
  localparam logic [15:0] RT_ANGLE    = 16'h1C05;
  localparam logic [15:0] RT_LAYER    = 16'h0D02;
  localparam logic [15:0] RT_STRANS   = 16'h1A01;

  // Smallest legal record length (header only)
  localparam logic [15:0] HDR_LEN = 16'd4;

  // Nesting flag bit positions
  localparam int unsigned NF_LIB  = 0;
  localparam int unsigned NF_CELL = 1;
  localparam int unsigned NF_GFX  = 2;
  localparam int unsigned NF_PATH = 3;
  localparam int unsigned NF_REF  = 4;
  localparam int unsigned NF_W    = 5;
  localparam logic [NF_W-1:0] NF_OPEN_MASK = 5'b10111;

  typedef enum logic [3:0] {
    EV_LIBBEG  = 4'd0,
    EV_LIBEND  = 4'd1,
    EV_CELLBEG = 4'd2,
    EV_CELLEND = 4'd3,
    EV_ELEMBEG = 4'd4,
    EV_ELEMEND = 4'd5,
    EV_VERTEX  = 4'd6,
    EV_ORIGIN  = 4'd7,
    EV_LAYER   = 4'd8,
    EV_FLIP    = 4'd9,
    EV_MAG     = 4'd10,
    EV_ANGLE   = 4'd11,
    EV_DONE    = 4'd12,
    EV_ERROR   = 4'd13
  } event_e;

  typedef enum logic [1:0] {
    KIND_BOUNDARY = 2'd0,
    KIND_PATH     = 2'd1,
    KIND_REF      = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE          = 4'd0,
    ERR_EOF_OPEN      = 4'd1,
    ERR_PAD_OPEN      = 4'd2,
    ERR_SHORT_HEADER  = 4'd3,
    ERR_SHORT_PAYLOAD = 4'd4,
    ERR_CLOSE_UNOPEN  = 4'd5,
    ERR_CLOSE_CHILD   = 4'd6,
    ERR_OUTSIDE       = 4'd7,
    ERR_GFX_AND_REF   = 4'd8
  } err_e;

  // Header phase, one-hot
  typedef enum logic [4:0] {
    PH_LEN_HI  = 5'b00001,
    PH_LEN_LO  = 5'b00010,
    PH_TYPE_HI = 5'b00100,
    PH_TYPE_LO = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  // Run status, one-hot
  typedef enum logic [2:0] {
    RUN_ACTIVE = 3'b001,
    RUN_DONE   = 3'b010,
    RUN_FAIL   = 3'b100
  } run_e;

  // One input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    event_e             event_res;
    kind_e              element_kind;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [15:0] layer_number;
    logic               flip_flag;
    logic [63:0]        real_raw;
    err_e               error_code;
  } event_t;

endpackage

// ----- rtl/core/gdsp_input_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdsp_input_stage
// Input register: captures one byte transaction and holds it until the
// parser consumes it.
// ----------------------------------------------------------------------------
module gdsp_input_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gdsp_pkg::in_item_t in_item_i,
  input  logic               consume_i,
  output logic               item_valid_o,
  output gdsp_pkg::in_item_t item_o
);
  import gdsp_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  // Accept when empty or when the held item leaves this cycle
  assign in_ready_o   = !valid_q || consume_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (consume_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

// ----- rtl/core/gdsp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdsp_parser
// Record framing and nesting tracker. Updates its state once per consumed
// byte and presents the event that byte causes, if any.
// ----------------------------------------------------------------------------
module gdsp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  gdsp_pkg::in_item_t item_i,
  output logic               ev_valid_o,
  output gdsp_pkg::event_t   ev_o
);
  import gdsp_pkg::*;

  phase_e          phase_q, phase_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     type_q, type_d;
  logic [15:0]     cnt_q, cnt_d;
  logic [NF_W-1:0] nest_q, nest_d;
  logic            org_q, org_d;
  logic [63:0]     shift_q, shift_d;
  run_e            run_q, run_d;

  logic [7:0]  b;
  logic [15:0] len_new;
  logic [15:0] type_new;
  logic [15:0] cnt_new;
  logic [63:0] shift_new;
  logic        open_any;
  kind_e       gfx_kind;

  function automatic event_t make_simple(event_e ev, kind_e kind);
    event_t e;
    e              = '0;
    e.event_res    = ev;
    e.element_kind = kind;
    return e;
  endfunction

  function automatic event_t make_error(err_e code);
    event_t e;
    e            = '0;
    e.event_res  = EV_ERROR;
    e.error_code = code;
    return e;
  endfunction

  assign b         = item_i.data_byte;
  assign len_new   = {len_q[15:8], b};
  assign type_new  = {type_q[15:8], b};
  assign cnt_new   = cnt_q + 16'd1;
  assign shift_new = {shift_q[55:0], b};
  assign open_any  = |(nest_q & NF_OPEN_MASK);
  assign gfx_kind  = nest_q[NF_PATH] ? KIND_PATH : KIND_BOUNDARY;

  // Next state and event for the byte at the head of the input register
  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    type_d     = type_q;
    cnt_d      = cnt_q;
    nest_d     = nest_q;
    org_d      = org_q;
    shift_d    = shift_q;
    run_d      = run_q;
    ev_valid_o = 1'b0;
    ev_o       = '0;

    if (run_q == RUN_ACTIVE) begin
      if (item_i.end_of_stream) begin
        // Final check
        ev_valid_o = 1'b1;
        if (phase_q == PH_LEN_HI || phase_q == PH_LEN_LO) begin
          if (open_any) begin
            run_d = RUN_FAIL;
            ev_o  = make_error(ERR_EOF_OPEN);
          end else begin
            run_d = RUN_DONE;
            ev_o  = make_simple(EV_DONE, KIND_BOUNDARY);
          end
        end else if (phase_q == PH_TYPE_HI || phase_q == PH_TYPE_LO) begin
          run_d = RUN_FAIL;
          ev_o  = make_error(ERR_SHORT_HEADER);
        end else begin
          run_d = RUN_FAIL;
          ev_o  = make_error(ERR_SHORT_PAYLOAD);
        end
      end else begin
        case (phase_q)
          PH_LEN_HI: begin
            len_d   = {b, 8'h00};
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_d = len_new;
            if (len_new < HDR_LEN) begin
              // A length below the header size is padding and ends the stream
              ev_valid_o = 1'b1;
              if (open_any) begin
                run_d = RUN_FAIL;
                ev_o  = make_error(ERR_PAD_OPEN);
              end else begin
                run_d = RUN_DONE;
                ev_o  = make_simple(EV_DONE, KIND_BOUNDARY);
              end
            end else begin
              phase_d = PH_TYPE_HI;
            end
          end
          PH_TYPE_HI: begin
            type_d  = {b, 8'h00};
            phase_d = PH_TYPE_LO;
          end
          PH_TYPE_LO: begin
            type_d = type_new;
            // Structure and element begin and end records
            case (type_new)
              RT_BGNLIB: begin
                nest_d[NF_LIB] = 1'b1;
                ev_valid_o     = 1'b1;
                ev_o           = make_simple(EV_LIBBEG, KIND_BOUNDARY);
              end
              RT_ENDLIB: begin
                ev_valid_o = 1'b1;
                if (!nest_q[NF_LIB]) begin
                  run_d = RUN_FAIL;
                  ev_o  = make_error(ERR_CLOSE_UNOPEN);
                end else if (nest_q[NF_CELL]) begin
                  run_d = RUN_FAIL;
                  ev_o  = make_error(ERR_CLOSE_CHILD);
                end else begin
                  nest_d[NF_LIB] = 1'b0;
                  ev_o           = make_simple(EV_LIBEND, KIND_BOUNDARY);
                end
              end
              RT_BGNSTR: begin
                ev_valid_o = 1'b1;
                if (!nest_q[NF_LIB]) begin
                  run_d = RUN_FAIL;
                  ev_o  = make_error(ERR_OUTSIDE);
                end else begin
                  nest_d[NF_CELL] = 1'b1;
                  ev_o            = make_simple(EV_CELLBEG, KIND_BOUNDARY);
                end
              end
              RT_ENDSTR: begin
                ev_valid_o = 1'b1;
                if (!nest_q[NF_CELL]) begin
                  run_d = RUN_FAIL;
                  ev_o  = make_error(ERR_CLOSE_UNOPEN);
                end else if (nest_q[NF_GFX] || nest_q[NF_REF]) begin
                  run_d = RUN_FAIL;
                  ev_o  = make_error(ERR_CLOSE_CHILD);
                end else begin
                  nest_d[NF_CELL] = 1'b0;
                  ev_o            = make_simple(EV_CELLEND, KIND_BOUNDARY);
                end
              end
              RT_BOUNDARY, RT_PATH: begin
                ev_valid_o = 1'b1;
                if (!nest_q[NF_CELL]) begin
                  run_d = RUN_FAIL;
                  ev_o  = make_error(ERR_OUTSIDE);
                end else begin
                  nest_d[NF_GFX]  = 1'b1;
                  nest_d[NF_PATH] = (type_new == RT_PATH);
                  ev_o = make_simple(EV_ELEMBEG,
                                     (type_new == RT_PATH) ? KIND_PATH : KIND_BOUNDARY);
                end
              end
              RT_SREF: begin
                ev_valid_o = 1'b1;
                if (!nest_q[NF_CELL]) begin
                  run_d = RUN_FAIL;
                  ev_o  = make_error(ERR_OUTSIDE);
                end else begin
                  nest_d[NF_REF] = 1'b1;
                  ev_o           = make_simple(EV_ELEMBEG, KIND_REF);
                end
              end
              RT_ENDEL: begin
                // Close whatever element is open; silent if none
                if (nest_q[NF_GFX] || nest_q[NF_REF]) begin
                  ev_valid_o      = 1'b1;
                  ev_o            = make_simple(EV_ELEMEND,
                                                nest_q[NF_GFX] ? gfx_kind : KIND_REF);
                  nest_d[NF_GFX]  = 1'b0;
                  nest_d[NF_PATH] = 1'b0;
                  nest_d[NF_REF]  = 1'b0;
                end
              end
              default: begin
              end
            endcase
            // Start the payload unless the record failed
            if (run_d == RUN_ACTIVE) begin
              cnt_d   = '0;
              shift_d = '0;
              org_d   = 1'b0;
              phase_d = (len_q == HDR_LEN) ? PH_LEN_HI : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            shift_d = shift_new;
            cnt_d   = cnt_new;
            // Payload decoding on the updated count and shift word
            case (type_q)
              RT_XY: begin
                if (nest_q[NF_REF]) begin
                  if (cnt_new == 16'd8 && !org_q) begin
                    org_d             = 1'b1;
                    ev_valid_o        = 1'b1;
                    ev_o              = make_simple(EV_ORIGIN, KIND_REF);
                    ev_o.coord_x      = shift_new[63:32];
                    ev_o.coord_y      = shift_new[31:0];
                  end
                end else if (nest_q[NF_GFX]) begin
                  if (cnt_new[2:0] == 3'd0) begin
                    ev_valid_o        = 1'b1;
                    ev_o              = make_simple(EV_VERTEX, gfx_kind);
                    ev_o.coord_x      = shift_new[63:32];
                    ev_o.coord_y      = shift_new[31:0];
                  end
                end
              end
              RT_LAYER: begin
                if (nest_q[NF_GFX] && cnt_new == 16'd2) begin
                  ev_valid_o        = 1'b1;
                  ev_o              = make_simple(EV_LAYER, gfx_kind);
                  ev_o.layer_number = shift_new[15:0];
                end
              end
              RT_STRANS: begin
                if (nest_q[NF_REF] && cnt_new == 16'd1) begin
                  ev_valid_o     = 1'b1;
                  ev_o           = make_simple(EV_FLIP, KIND_REF);
                  ev_o.flip_flag = b[7];
                end
              end
              RT_MAG, RT_ANGLE: begin
                if (cnt_new == 16'd8) begin
                  if (nest_q[NF_GFX] && nest_q[NF_REF]) begin
                    run_d      = RUN_FAIL;
                    ev_valid_o = 1'b1;
                    ev_o       = make_error(ERR_GFX_AND_REF);
                  end else if (nest_q[NF_REF]) begin
                    ev_valid_o    = 1'b1;
                    ev_o          = make_simple((type_q == RT_MAG) ? EV_MAG : EV_ANGLE,
                                                KIND_REF);
                    ev_o.real_raw = shift_new;
                  end
                end
              end
              default: begin
              end
            endcase
            // Return to the header after the last payload byte
            if (run_d == RUN_ACTIVE && cnt_new >= (len_q - HDR_LEN)) begin
              phase_d = PH_LEN_HI;
            end
          end
          default: begin
            phase_d = PH_LEN_HI;
          end
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN_HI;
      len_q   <= '0;
      type_q  <= '0;
      cnt_q   <= '0;
      nest_q  <= '0;
      org_q   <= 1'b0;
      shift_q <= '0;
      run_q   <= RUN_ACTIVE;
    end else if (advance_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      type_q  <= type_d;
      cnt_q   <= cnt_d;
      nest_q  <= nest_d;
      org_q   <= org_d;
      shift_q <= shift_d;
      run_q   <= run_d;
    end
  end

endmodule

// ----- rtl/core/gdsp_output_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdsp_output_stage
// Result register: holds one event transaction until the sink takes it.
// ----------------------------------------------------------------------------
module gdsp_output_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             ev_valid_i,
  input  gdsp_pkg::event_t ev_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             free_o,
  output gdsp_pkg::event_t ev_o
);
  import gdsp_pkg::*;

  logic   valid_q;
  event_t ev_q;

  // Room for a new event when empty or draining this cycle
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign ev_o        = ev_q;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= ev_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (load_i && ev_valid_i) begin
      ev_q <= ev_i;
    end
  end

endmodule

// ----- rtl/core/gdsii_record_stream_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdsii_record_stream_parser
// Each accepted byte waits in the input register and its event, if any, is
//   then captured in the result register; parser state updates in one pass.
// Throughput: one byte per cycle while the result register has room.
// Reset (rst_ni low, asynchronous): all records closed, header expected,
//   run status back to running, both registers empty.
// Frames GDSII records from a byte stream and emits structure events.
// ----------------------------------------------------------------------------
module gdsii_record_stream_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  // data_byte [7:0]
  input  logic [7:0]    s_axis_tdata,
  input  logic          s_axis_tlast,   // end_of_stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // coord_x [31:0], coord_y [63:32], layer_number [79:64], flip_flag [80],
  // real_raw [144:81], error_code [148:145], zero [151:149]
  output logic [151:0]  m_axis_tdata,
  // event_res [3:0], element_kind [5:4]
  output logic [5:0]    m_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready
);
  import gdsp_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     out_free;
  logic     advance;
  logic     ev_valid;
  event_t   ev;
  event_t   ev_out;

  assign in_item.data_byte     = s_axis_tdata;
  assign in_item.end_of_stream = s_axis_tlast;

  // Move a byte through the parser when the result register has room
  assign advance = item_valid && out_free;

  gdsp_input_stage u_input_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .consume_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  gdsp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .item_i     (item),
    .ev_valid_o (ev_valid),
    .ev_o       (ev)
  );

  gdsp_output_stage u_output_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .ev_valid_i  (ev_valid),
    .ev_i        (ev),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .free_o      (out_free),
    .ev_o        (ev_out)
  );

  // Pack the result transaction
  assign m_axis_tuser = {ev_out.element_kind, ev_out.event_res};
  assign m_axis_tdata = {3'b000, ev_out.error_code, ev_out.real_raw, ev_out.flip_flag,
                         ev_out.layer_number, ev_out.coord_y, ev_out.coord_x};

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives one long GDSII byte stream into the record parser: a few fixed
// records with extreme origin words, then random but properly nested
// libraries, cells, boundaries, paths and references mixed with stray and
// misplaced records. The stream closes with a randomly chosen clean finish
// or error, followed by bytes the parser must ignore. A scoreboard predicts
// every event from the accepted bytes and checks the output stream in order.
// Both sides idle at random. The receiver once holds off long enough to
// back the parser up, and the sender once drains all pending events.
// ----------------------------------------------------------------------------
module testbench;
  import gdsp_pkg::*;

  localparam int ITEM_TARGET = 1750;
  localparam int PAUSE_AT    = 900;
  localparam int HOLD_AT     = 24;
  localparam int HOLD_CYCLES = 300;

  typedef logic [7:0] byte_q_t[$];

  typedef enum int {
    IDLE_NONE,
    IDLE_FULL,
    IDLE_SPARSE
  } idle_e;

  // Ways to close the stream
  typedef enum int {
    END_CLEAN_EOS,
    END_CLEAN_PAD,
    END_EOF_OPEN,
    END_PAD_OPEN,
    END_SHORT_HEADER,
    END_SHORT_PAYLOAD,
    END_CLOSE_UNOPEN,
    END_CLOSE_CHILD,
    END_OUTSIDE,
    END_GFX_AND_REF
  } finale_e;

  // --------------------------------------------------------------------------
  // Scoreboard: parser state tracker and the queue of pending events
  // --------------------------------------------------------------------------
  class event_ledger;
    phase_e          phase;
    run_e            run;
    logic [15:0]     rec_len;
    logic [15:0]     rec_code;
    logic [15:0]     pay_cnt;
    logic [NF_W-1:0] nest;
    logic            origin_done;
    logic [63:0]     shift;
    event_t          awaited[$];
    int unsigned     mismatches;
    int unsigned     results_seen;

    function new();
      phase        = PH_LEN_HI;
      run          = RUN_ACTIVE;
      rec_len      = '0;
      rec_code     = '0;
      pay_cnt      = '0;
      nest         = '0;
      origin_done  = 1'b0;
      shift        = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function event_t blank(event_e ev, kind_e kind);
      event_t e;
      e              = '0;
      e.event_res    = ev;
      e.element_kind = kind;
      e.error_code   = ERR_NONE;
      return e;
    endfunction

    function kind_e gfx_kind();
      return nest[NF_PATH] ? KIND_PATH : KIND_BOUNDARY;
    endfunction

    function void raise(err_e code);
      event_t e;
      e            = blank(EV_ERROR, KIND_BOUNDARY);
      e.error_code = code;
      run          = RUN_FAIL;
      awaited.push_back(e);
    endfunction

    // End the run: done when nothing is open, else the given error
    function void wrap_up(err_e code);
      if ((nest & NF_OPEN_MASK) != '0) begin
        raise(code);
      end else begin
        run = RUN_DONE;
        awaited.push_back(blank(EV_DONE, KIND_BOUNDARY));
      end
    endfunction

    // Act on a complete record type
    function void open_record();
      kind_e k;
      case (rec_code)
        RT_BGNLIB: begin
          nest[NF_LIB] = 1'b1;
          awaited.push_back(blank(EV_LIBBEG, KIND_BOUNDARY));
        end
        RT_ENDLIB: begin
          if (!nest[NF_LIB]) raise(ERR_CLOSE_UNOPEN);
          else if (nest[NF_CELL]) raise(ERR_CLOSE_CHILD);
          else begin
            nest[NF_LIB] = 1'b0;
            awaited.push_back(blank(EV_LIBEND, KIND_BOUNDARY));
          end
        end
        RT_BGNSTR: begin
          if (!nest[NF_LIB]) raise(ERR_OUTSIDE);
          else begin
            nest[NF_CELL] = 1'b1;
            awaited.push_back(blank(EV_CELLBEG, KIND_BOUNDARY));
          end
        end
        RT_ENDSTR: begin
          if (!nest[NF_CELL]) raise(ERR_CLOSE_UNOPEN);
          else if (nest[NF_GFX] || nest[NF_REF]) raise(ERR_CLOSE_CHILD);
          else begin
            nest[NF_CELL] = 1'b0;
            awaited.push_back(blank(EV_CELLEND, KIND_BOUNDARY));
          end
        end
        RT_BOUNDARY, RT_PATH: begin
          if (!nest[NF_CELL]) raise(ERR_OUTSIDE);
          else begin
            nest[NF_GFX]  = 1'b1;
            nest[NF_PATH] = (rec_code == RT_PATH);
            awaited.push_back(blank(EV_ELEMBEG, gfx_kind()));
          end
        end
        RT_SREF: begin
          if (!nest[NF_CELL]) raise(ERR_OUTSIDE);
          else begin
            nest[NF_REF] = 1'b1;
            awaited.push_back(blank(EV_ELEMBEG, KIND_REF));
          end
        end
        RT_ENDEL: begin
          // A stray element end closes nothing and reports nothing
          if (nest[NF_GFX] || nest[NF_REF]) begin
            k = nest[NF_GFX] ? gfx_kind() : KIND_REF;
            nest[NF_GFX]  = 1'b0;
            nest[NF_PATH] = 1'b0;
            nest[NF_REF]  = 1'b0;
            awaited.push_back(blank(EV_ELEMEND, k));
          end
        end
        default: ;
      endcase
    endfunction

    // Shift in one payload byte and report what it completes
    function void take_payload(logic [7:0] b);
      event_t e;
      shift   = {shift[55:0], b};
      pay_cnt = pay_cnt + 16'd1;
      case (rec_code)
        RT_XY: begin
          if (nest[NF_REF]) begin
            if (pay_cnt == 16'd8 && !origin_done) begin
              origin_done = 1'b1;
              e           = blank(EV_ORIGIN, KIND_REF);
              e.coord_x   = shift[63:32];
              e.coord_y   = shift[31:0];
              awaited.push_back(e);
            end
          end else if (nest[NF_GFX] && pay_cnt[2:0] == 3'd0) begin
            e         = blank(EV_VERTEX, gfx_kind());
            e.coord_x = shift[63:32];
            e.coord_y = shift[31:0];
            awaited.push_back(e);
          end
        end
        RT_LAYER: begin
          if (nest[NF_GFX] && pay_cnt == 16'd2) begin
            e              = blank(EV_LAYER, gfx_kind());
            e.layer_number = shift[15:0];
            awaited.push_back(e);
          end
        end
        RT_STRANS: begin
          if (nest[NF_REF] && pay_cnt == 16'd1) begin
            e           = blank(EV_FLIP, KIND_REF);
            e.flip_flag = b[7];
            awaited.push_back(e);
          end
        end
        RT_MAG, RT_ANGLE: begin
          if (pay_cnt == 16'd8) begin
            if (nest[NF_GFX] && nest[NF_REF]) raise(ERR_GFX_AND_REF);
            else if (nest[NF_REF]) begin
              e          = blank((rec_code == RT_MAG) ? EV_MAG : EV_ANGLE, KIND_REF);
              e.real_raw = shift;
              awaited.push_back(e);
            end
          end
        end
        default: ;
      endcase
      if (run == RUN_ACTIVE && pay_cnt >= rec_len - HDR_LEN) phase = PH_LEN_HI;
    endfunction

    // Note one accepted input transaction
    function void note_byte(logic [7:0] b, logic eos);
      if (run != RUN_ACTIVE) return;
      if (eos) begin
        case (phase)
          PH_LEN_HI, PH_LEN_LO:   wrap_up(ERR_EOF_OPEN);
          PH_TYPE_HI, PH_TYPE_LO: raise(ERR_SHORT_HEADER);
          default:                raise(ERR_SHORT_PAYLOAD);
        endcase
        return;
      end
      case (phase)
        PH_LEN_HI: begin
          rec_len = {b, 8'h00};
          phase   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          rec_len[7:0] = b;
          if (rec_len < HDR_LEN) wrap_up(ERR_PAD_OPEN);
          else phase = PH_TYPE_HI;
        end
        PH_TYPE_HI: begin
          rec_code = {b, 8'h00};
          phase    = PH_TYPE_LO;
        end
        PH_TYPE_LO: begin
          rec_code[7:0] = b;
          open_record();
          if (run == RUN_ACTIVE) begin
            pay_cnt     = '0;
            shift       = '0;
            origin_done = 1'b0;
            phase       = (rec_len == HDR_LEN) ? PH_LEN_HI : PH_PAYLOAD;
          end
        end
        default: take_payload(b);
      endcase
    endfunction

    function string show(event_t e);
      return $sformatf("ev=%0d kind=%0d x=%h y=%h layer=%h flip=%b real=%h err=%0d",
                       e.event_res, e.element_kind, e.coord_x, e.coord_y,
                       e.layer_number, e.flip_flag, e.real_raw, e.error_code);
    endfunction

    // Check one accepted output transaction against the oldest prediction
    function void check_event(logic [5:0] user, logic [151:0] data);
      event_t got;
      event_t want;
      got.event_res    = event_e'(user[3:0]);
      got.element_kind = kind_e'(user[5:4]);
      got.coord_x      = data[31:0];
      got.coord_y      = data[63:32];
      got.layer_number = data[79:64];
      got.flip_flag    = data[80];
      got.real_raw     = data[144:81];
      got.error_code   = err_e'(data[148:145]);
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("event %0d not predicted: %s", results_seen, show(got));
        return;
      end
      want = awaited.pop_front();
      if (got.event_res !== want.event_res || got.element_kind !== want.element_kind ||
          got.coord_x !== want.coord_x || got.coord_y !== want.coord_y ||
          got.layer_number !== want.layer_number || got.flip_flag !== want.flip_flag ||
          got.real_raw !== want.real_raw || got.error_code !== want.error_code) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("event %0d mismatch", results_seen);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [151:0] m_axis_tdata;
  logic [5:0]   m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;

  event_ledger ledger = new();

  idle_e src_mode   = IDLE_NONE;
  int    src_left   = 0;
  idle_e sink_mode  = IDLE_NONE;
  int    sink_left  = 0;
  int    bytes_sent = 0;

  always #1 clk_i = ~clk_i;

  gdsii_record_stream_parser u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int idle_cycles(idle_e mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 12);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
    endcase
  endfunction

  // Word with a bias toward sign and range limits
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Any type the parser does not act on
  function automatic logic [15:0] stray_type();
    logic [15:0] t;
    t = 16'($urandom);
    while (t inside {RT_BGNLIB, RT_ENDLIB, RT_BGNSTR, RT_ENDSTR, RT_BOUNDARY, RT_PATH,
                     RT_SREF, RT_ENDEL, RT_XY, RT_MAG, RT_ANGLE, RT_LAYER, RT_STRANS})
      t = 16'($urandom);
    return t;
  endfunction

  function automatic logic [15:0] pick_element();
    case ($urandom_range(0, 2))
      0:       return RT_BOUNDARY;
      1:       return RT_PATH;
      default: return RT_SREF;
    endcase
  endfunction

  // Append n bytes: the first w from v, big-endian, the rest random
  function automatic void put_be(ref byte_q_t q, input logic [63:0] v, input int w,
                                 input int n);
    for (int i = 0; i < n; i++) begin
      if (i < w) q.push_back(v[8*(w-1-i) +: 8]);
      else q.push_back(8'($urandom));
    end
  endfunction

  // Offer one byte and hold it until the parser takes it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (src_left == 0) begin
      src_mode = idle_e'($urandom_range(0, 2));
      src_left = $urandom_range(10, 60);
    end
    src_left--;
    gap = idle_cycles(src_mode);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_byte(b, eos);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_record(input logic [15:0] rtype, input byte_q_t body);
    logic [15:0] len;
    len = 16'(4 + body.size());
    send_byte(len[15:8], 1'b0);
    send_byte(len[7:0], 1'b0);
    send_byte(rtype[15:8], 1'b0);
    send_byte(rtype[7:0], 1'b0);
    foreach (body[i]) send_byte(body[i], 1'b0);
  endtask

  task automatic send_bare(input logic [15:0] rtype);
    byte_q_t none;
    send_record(rtype, none);
  endtask

  task automatic close_all();
    if (ledger.nest[NF_GFX] || ledger.nest[NF_REF]) send_bare(RT_ENDEL);
    if (ledger.nest[NF_CELL]) send_bare(RT_ENDSTR);
    if (ledger.nest[NF_LIB]) send_bare(RT_ENDLIB);
  endtask

  task automatic open_cell();
    if (!ledger.nest[NF_LIB]) send_bare(RT_BGNLIB);
    if (!ledger.nest[NF_CELL]) send_bare(RT_BGNSTR);
  endtask

  // Append one record that fits the current nesting, or a harmless stray one
  task automatic grow_stream();
    byte_q_t     body;
    int          roll;
    int          pick;
    logic        in_gfx;
    logic        in_ref;
    logic [31:0] w;
    roll   = $urandom_range(0, 99);
    pick   = $urandom_range(0, 99);
    in_gfx = ledger.nest[NF_GFX];
    in_ref = ledger.nest[NF_REF];
    if (roll < 8) begin
      // Unknown or misplaced record: parser must skip it silently
      if (in_gfx || in_ref || roll < 4) begin
        put_be(body, '0, 0, ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300)
                                                         : $urandom_range(0, 12));
        send_record(stray_type(), body);
      end else begin
        put_be(body, '0, 0, $urandom_range(0, 12));
        case ($urandom_range(0, 4))
          0:       send_record(RT_XY, body);
          1:       send_record(RT_LAYER, body);
          2:       send_record(RT_STRANS, body);
          3:       send_record(RT_MAG, body);
          default: send_record(RT_ANGLE, body);
        endcase
      end
    end else if (!ledger.nest[NF_LIB]) begin
      put_be(body, '0, 0, $urandom_range(0, 28));
      send_record(RT_BGNLIB, body);
    end else if (!ledger.nest[NF_CELL]) begin
      if (pick < 80) begin
        put_be(body, '0, 0, $urandom_range(0, 28));
        send_record(RT_BGNSTR, body);
      end else if (pick < 95) send_bare(RT_ENDLIB);
      else send_bare(RT_BGNLIB);
    end else if (!in_gfx && !in_ref) begin
      if (pick < 30) send_bare(RT_BOUNDARY);
      else if (pick < 55) send_bare(RT_PATH);
      else if (pick < 85) send_bare(RT_SREF);
      else if (pick < 95) send_bare(RT_ENDSTR);
      else if (pick < 98) send_bare(RT_ENDEL);
      else send_bare(RT_BGNSTR);
    end else if (pick < 35) begin
      // Coordinates: one origin per reference record, else vertex list
      if (in_ref) begin
        roll = $urandom_range(0, 5);
        put_be(body, {pick_word(), pick_word()}, 8, (roll == 0) ? 4 : (roll == 1) ? 16 : 8);
      end else begin
        repeat (($urandom_range(0, 19) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5))
          put_be(body, {pick_word(), pick_word()}, 8, 8);
        if ($urandom_range(0, 4) == 0) put_be(body, '0, 0, $urandom_range(1, 7));
      end
      send_record(RT_XY, body);
    end else if (pick < 50) begin
      w = pick_word();
      roll = $urandom_range(0, 7);
      put_be(body, {48'd0, w[31:16]}, 2, (roll == 0) ? 0 : (roll == 1) ? 1 : (roll == 2) ? 4 : 2);
      send_record(RT_LAYER, body);
    end else if (pick < 60) begin
      put_be(body, '0, 0, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : 2);
      send_record(RT_STRANS, body);
    end else if (pick < 70) begin
      // Keep reals short while both element kinds are open
      roll = $urandom_range(0, 5);
      if (in_gfx && in_ref) roll = $urandom_range(0, 7);
      else roll = (roll == 0) ? 4 : (roll == 1) ? 12 : 8;
      put_be(body, {pick_word(), pick_word()}, 8, roll);
      send_record(($urandom_range(0, 1) == 0) ? RT_MAG : RT_ANGLE, body);
    end else if (pick < 90) send_bare(RT_ENDEL);
    else send_bare(pick_element());
  endtask

  // Bring the stream to its one done or error event
  task automatic end_stream(input finale_e how);
    byte_q_t     body;
    logic [15:0] t;
    int          len;
    case (how)
      END_CLEAN_EOS: begin
        close_all();
        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
      END_CLEAN_PAD: begin
        close_all();
        send_byte(8'h00, 1'b0);
        send_byte(8'($urandom_range(0, 3)), 1'b0);
      end
      END_EOF_OPEN: begin
        if (!ledger.nest[NF_LIB]) send_bare(RT_BGNLIB);
        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
      END_PAD_OPEN: begin
        if (!ledger.nest[NF_LIB]) send_bare(RT_BGNLIB);
        send_byte(8'h00, 1'b0);
        send_byte(8'($urandom_range(0, 3)), 1'b0);
      end
      END_SHORT_HEADER: begin
        send_byte(8'h00, 1'b0);
        send_byte(8'($urandom_range(4, 40)), 1'b0);
        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
      END_SHORT_PAYLOAD: begin
        len = $urandom_range(5, 40);
        t   = stray_type();
        send_byte(8'h00, 1'b0);
        send_byte(8'(len), 1'b0);
        send_byte(t[15:8], 1'b0);
        send_byte(t[7:0], 1'b0);
        repeat ($urandom_range(0, len - 5)) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
      END_CLOSE_UNOPEN: begin
        if ($urandom_range(0, 1) == 0) begin
          close_all();
          send_bare(($urandom_range(0, 1) == 0) ? RT_ENDLIB : RT_ENDSTR);
        end else begin
          if (!ledger.nest[NF_LIB]) send_bare(RT_BGNLIB);
          if (ledger.nest[NF_GFX] || ledger.nest[NF_REF]) send_bare(RT_ENDEL);
          if (ledger.nest[NF_CELL]) send_bare(RT_ENDSTR);
          send_bare(RT_ENDSTR);
        end
      end
      END_CLOSE_CHILD: begin
        open_cell();
        if ($urandom_range(0, 1) == 0) send_bare(RT_ENDLIB);
        else begin
          if (!ledger.nest[NF_GFX] && !ledger.nest[NF_REF]) send_bare(pick_element());
          send_bare(RT_ENDSTR);
        end
      end
      END_OUTSIDE: begin
        if ($urandom_range(0, 1) == 0) begin
          close_all();
          send_bare(RT_BGNSTR);
        end else begin
          if (ledger.nest[NF_GFX] || ledger.nest[NF_REF]) send_bare(RT_ENDEL);
          if (ledger.nest[NF_CELL]) send_bare(RT_ENDSTR);
          if ($urandom_range(0, 1) == 0 && ledger.nest[NF_LIB]) send_bare(RT_ENDLIB);
          send_bare(pick_element());
        end
      end
      default: begin
        open_cell();
        if (!ledger.nest[NF_GFX]) send_bare(($urandom_range(0, 1) == 0) ? RT_BOUNDARY : RT_PATH);
        if (!ledger.nest[NF_REF]) send_bare(RT_SREF);
        put_be(body, {pick_word(), pick_word()}, 8, $urandom_range(8, 12));
        send_record(($urandom_range(0, 1) == 0) ? RT_MAG : RT_ANGLE, body);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sender: reset, fixed opening, random stream, finish, ignored tail
  // --------------------------------------------------------------------------
  initial begin : source
    byte_q_t body;
    logic    paused;
    paused        = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Open a reference and give it an origin at the coordinate limits
    send_bare(RT_BGNLIB);
    send_bare(RT_BGNSTR);
    send_bare(RT_SREF);
    put_be(body, {32'h7FFF_FFFF, 32'h8000_0000}, 8, 8);
    send_record(RT_XY, body);

    while (bytes_sent < ITEM_TARGET) begin
      if (!paused && bytes_sent >= PAUSE_AT) begin
        // Drain every pending event before going on
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (ledger.awaited.size() != 0) @(negedge clk_i);
      end
      grow_stream();
    end
    end_stream(finale_e'($urandom_range(0, 9)));

    // Parser is finished: these must produce nothing
    repeat ($urandom_range(8, 16)) send_byte(8'($urandom), $urandom_range(0, 5) == 0);
    s_axis_tvalid <= 1'b0;

    while (ledger.awaited.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (ledger.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready gaps and one long hold-off
  // --------------------------------------------------------------------------
  initial begin : sink
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (sink_left == 0) begin
        sink_mode = idle_e'($urandom_range(0, 2));
        sink_left = $urandom_range(5, 40);
      end
      sink_left--;
      gap = idle_cycles(sink_mode);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      ledger.check_event(m_axis_tuser, m_axis_tdata);
      @(negedge clk_i);
      if (ledger.results_seen == HOLD_AT) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
    end
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
